[sv/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// Types and constants shared by the client connection state machine modules.
// ----------------------------------------------------------------------------
package tcc_pkg;

    typedef enum logic [1:0] {
        MODE_SEGMENT = 2'd0,
        MODE_SEND    = 2'd1,
        MODE_CLOSE   = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLOSED      = 3'd0,
        ST_SYN_SENT    = 3'd1,
        ST_ESTABLISHED = 3'd2,
        ST_CLOSE_WAIT  = 3'd3,
        ST_FIN_WAIT_1  = 3'd4
    } link_state_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_SYN    = 3'd1,
        ACT_ACK    = 3'd2,
        ACT_FINACK = 3'd3,
        ACT_RST    = 3'd4,
        ACT_DATA   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_NORMAL  = 3'd1,
        EV_REFUSED = 3'd2,
        EV_RESET   = 3'd3,
        EV_UNKNOWN = 3'd4
    } close_event_t;

    localparam int FLAGS_W = 9;

    localparam logic [FLAGS_W-1:0] F_FIN = 9'h001;
    localparam logic [FLAGS_W-1:0] F_SYN = 9'h002;
    localparam logic [FLAGS_W-1:0] F_RST = 9'h004;
    localparam logic [FLAGS_W-1:0] F_ACK = 9'h010;
    localparam logic [FLAGS_W-1:0] F_URG = 9'h020;
    localparam logic [FLAGS_W-1:0] F_CWR = 9'h080;
    localparam logic [FLAGS_W-1:0] F_NS  = 9'h100;

    // one queue entry: the results caused by one input item
    typedef struct packed {
        action_t      act;
        logic [31:0]  seq;
        logic [31:0]  ack;
        logic [15:0]  slen;
        logic [15:0]  rlen;
        close_event_t event_code;
        logic         two;
        link_state_t  state;
    } job_t;

endpackage

[sv/tcc_front.sv]
// ----------------------------------------------------------------------------
// tcc_front
// Classifies each input item, updates the connection state and builds the
// job record of results it causes.
// ----------------------------------------------------------------------------
module tcc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 accept,
    input  logic [1:0]           mode,
    input  logic [8:0]           flags,
    input  logic [31:0]          seq_in,
    input  logic [3:0]           data_offset,
    input  logic [15:0]          segment_length,
    input  logic [15:0]          send_size,
    output logic                 push,
    output tcc_pkg::job_t        job
);

    tcc_pkg::link_state_t link_state_reg, link_state_next;
    logic [31:0] own_seq_reg, own_seq_next;
    logic [31:0] expected_ack_reg, expected_ack_next;
    logic [15:0] pending_len_reg, pending_len_next;
    logic [31:0] init_seq_reg;

    logic [5:0]  hdr_len;
    logic [15:0] payload;
    logic [31:0] ack_calc;
    logic [31:0] own_plus1;
    logic        has_syn, has_fin, has_ack, has_rst, bad_flags;
    logic        make;
    tcc_pkg::mode_t mode_dec;

    assign mode_dec  = tcc_pkg::mode_t'(mode);
    assign hdr_len   = {data_offset, 2'b00};
    assign payload   = (segment_length > {10'd0, hdr_len}) ?
                       segment_length - {10'd0, hdr_len} : 16'd0;
    assign has_syn   = |(flags & tcc_pkg::F_SYN);
    assign has_fin   = |(flags & tcc_pkg::F_FIN);
    assign has_ack   = |(flags & tcc_pkg::F_ACK);
    assign has_rst   = |(flags & tcc_pkg::F_RST);
    assign bad_flags = |(flags & (tcc_pkg::F_NS | tcc_pkg::F_CWR | tcc_pkg::F_URG));
    assign ack_calc  = seq_in + {16'd0, payload} + {31'd0, has_syn | has_fin};
    assign own_plus1 = own_seq_reg + 32'd1;

    always_comb begin
        link_state_next   = link_state_reg;
        own_seq_next      = own_seq_reg;
        expected_ack_next = expected_ack_reg;
        pending_len_next  = pending_len_reg;
        make              = 1'b0;
        job               = '0;
        job.act           = tcc_pkg::ACT_NONE;
        job.event_code    = tcc_pkg::EV_NONE;
        unique case (mode_dec)
            tcc_pkg::MODE_SEND: begin
                make = 1'b1;
                if (link_state_reg == tcc_pkg::ST_CLOSED) begin
                    pending_len_next = send_size;
                    own_seq_next     = init_seq_reg;
                    link_state_next  = tcc_pkg::ST_SYN_SENT;
                    job.act          = tcc_pkg::ACT_SYN;
                    job.seq          = init_seq_reg;
                    job.ack          = expected_ack_reg;
                end else begin
                    job.act      = tcc_pkg::ACT_DATA;
                    job.seq      = own_seq_reg;
                    job.ack      = expected_ack_reg;
                    job.slen     = send_size;
                    own_seq_next = own_seq_reg + {16'd0, send_size};
                end
            end
            tcc_pkg::MODE_CLOSE: begin
                if (link_state_reg == tcc_pkg::ST_ESTABLISHED) begin
                    make            = 1'b1;
                    job.act         = tcc_pkg::ACT_FINACK;
                    job.seq         = own_seq_reg;
                    job.ack         = expected_ack_reg;
                    link_state_next = tcc_pkg::ST_FIN_WAIT_1;
                end
            end
            tcc_pkg::MODE_SEGMENT: begin
                priority if (bad_flags) begin
                    make    = 1'b1;
                    job.act = tcc_pkg::ACT_RST;
                    job.seq = own_seq_reg;
                    job.ack = expected_ack_reg;
                end else if (has_syn && has_ack &&
                             link_state_reg == tcc_pkg::ST_SYN_SENT) begin
                    // handshake ack, then the held-back first send
                    make              = 1'b1;
                    expected_ack_next = ack_calc;
                    job.act           = tcc_pkg::ACT_ACK;
                    job.seq           = own_plus1;
                    job.ack           = ack_calc;
                    job.two           = 1'b1;
                    job.slen          = pending_len_reg;
                    own_seq_next      = own_plus1 + {16'd0, pending_len_reg};
                    pending_len_next  = 16'd0;
                    link_state_next   = tcc_pkg::ST_ESTABLISHED;
                end else if (flags == tcc_pkg::F_ACK &&
                             link_state_reg == tcc_pkg::ST_CLOSE_WAIT) begin
                    make            = 1'b1;
                    job.event_code  = tcc_pkg::EV_NORMAL;
                    link_state_next = tcc_pkg::ST_CLOSED;
                end else if (has_fin && has_ack &&
                             link_state_reg == tcc_pkg::ST_FIN_WAIT_1) begin
                    make              = 1'b1;
                    expected_ack_next = ack_calc;
                    job.act           = tcc_pkg::ACT_ACK;
                    job.seq           = own_seq_reg;
                    job.ack           = ack_calc;
                    job.event_code    = tcc_pkg::EV_NORMAL;
                    link_state_next   = tcc_pkg::ST_CLOSED;
                end else if (flags == (tcc_pkg::F_RST | tcc_pkg::F_ACK) &&
                             link_state_reg == tcc_pkg::ST_SYN_SENT) begin
                    make            = 1'b1;
                    job.event_code  = tcc_pkg::EV_REFUSED;
                    link_state_next = tcc_pkg::ST_CLOSED;
                end else if (has_ack && link_state_reg == tcc_pkg::ST_ESTABLISHED) begin
                    // bare ack with no data and no fin is silent
                    if (payload != 16'd0 || has_fin) begin
                        make              = 1'b1;
                        expected_ack_next = ack_calc;
                        job.act           = has_fin ? tcc_pkg::ACT_FINACK
                                                    : tcc_pkg::ACT_ACK;
                        job.seq           = own_seq_reg;
                        job.ack           = ack_calc;
                        job.rlen          = payload;
                        if (has_fin) begin
                            link_state_next = tcc_pkg::ST_CLOSE_WAIT;
                        end
                    end
                end else if (has_rst) begin
                    make            = 1'b1;
                    job.event_code  = tcc_pkg::EV_RESET;
                    link_state_next = tcc_pkg::ST_CLOSED;
                end else begin
                    make            = 1'b1;
                    job.act         = tcc_pkg::ACT_RST;
                    job.seq         = own_seq_reg;
                    job.ack         = expected_ack_reg;
                    job.event_code  = tcc_pkg::EV_UNKNOWN;
                    link_state_next = tcc_pkg::ST_CLOSED;
                end
            end
            default: begin
            end
        endcase
        job.state = link_state_next;
    end

    assign push = accept & make;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_state_reg   <= tcc_pkg::ST_CLOSED;
            own_seq_reg      <= 32'd0;
            expected_ack_reg <= 32'd0;
            pending_len_reg  <= 16'd0;
            init_seq_reg     <= 32'd0;
        end else begin
            if (cfg_wr_en) begin
                init_seq_reg <= cfg_wr_data;
            end
            if (accept) begin
                link_state_reg   <= link_state_next;
                own_seq_reg      <= own_seq_next;
                expected_ack_reg <= expected_ack_next;
                pending_len_reg  <= pending_len_next;
            end
        end
    end

endmodule

[sv/tcc_queue.sv]
// ----------------------------------------------------------------------------
// tcc_queue
// Short first-in first-out queue of job records between front and back.
// ----------------------------------------------------------------------------
module tcc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tcc_pkg::job_t wr_job,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output tcc_pkg::job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

    tcc_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

[sv/tcc_back.sv]
// ----------------------------------------------------------------------------
// tcc_back
// Plays out the results of the job at the queue head, one per transfer.
// ----------------------------------------------------------------------------
module tcc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          empty,
    input  tcc_pkg::job_t head,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_action,
    output logic [31:0]   m_seq_out,
    output logic [31:0]   m_ack_out,
    output logic [15:0]   m_send_len,
    output logic [15:0]   m_recv_len,
    output logic [2:0]    m_conn_state,
    output logic [2:0]    m_close_event,
    output logic          m_last
);

    // set while the second result of a two-result job is on show
    logic second_reg, second_next;
    logic xfer;

    assign m_valid = !empty;
    assign xfer    = m_valid & m_ready;
    assign pop     = xfer & (!head.two | second_reg);

    always_comb begin
        second_next = second_reg;
        if (xfer) begin
            second_next = head.two & !second_reg;
        end
    end

    always_comb begin
        m_seq_out    = head.seq;
        m_ack_out    = head.ack;
        m_conn_state = head.state;
        if (second_reg) begin
            m_action      = tcc_pkg::ACT_DATA;
            m_send_len    = head.slen;
            m_recv_len    = 16'd0;
            m_close_event = tcc_pkg::EV_NONE;
            m_last        = 1'b1;
        end else begin
            m_action      = head.act;
            m_send_len    = head.two ? 16'd0 : head.slen;
            m_recv_len    = head.rlen;
            m_close_event = head.event_code;
            m_last        = !head.two;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else begin
            second_reg <= second_next;
        end
    end

endmodule

[sv/tcp_client_connection_fsm_top.sv]
// latency: a result is registered into the job queue on its input transfer and
// is offered from the queue head; throughput: one input item per cycle while
// the queue is not full; a handshake answer yields two results and holds the
// result port for two transfers, absorbed by the job queue; the state update in
// the front stage sets the input rate; reset: synchronous active-low aresetn
// clears state to closed, numbers to zero and empties the queue
// ----------------------------------------------------------------------------
// tcp_client_connection_fsm_top
// Client side of one TCP connection: classifying front, job queue and
// result back end.
// ----------------------------------------------------------------------------
module tcp_client_connection_fsm_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [8:0]  s_flags,
    input  logic [31:0] s_seq_in,
    input  logic [3:0]  s_data_offset,
    input  logic [15:0] s_segment_length,
    input  logic [15:0] s_send_size,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [31:0] m_seq_out,
    output logic [31:0] m_ack_out,
    output logic [15:0] m_send_len,
    output logic [15:0] m_recv_len,
    output logic [2:0]  m_conn_state,
    output logic [2:0]  m_close_event,
    output logic        m_last
);

    tcc_pkg::job_t new_job, head_job;
    logic push, pop, full, empty, accept;

    assign s_ready = !full;
    assign accept  = s_valid & s_ready;

    tcc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .accept         (accept),
        .mode           (s_mode),
        .flags          (s_flags),
        .seq_in         (s_seq_in),
        .data_offset    (s_data_offset),
        .segment_length (s_segment_length),
        .send_size      (s_send_size),
        .push           (push),
        .job            (new_job)
    );

    tcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_job  (new_job),
        .pop     (pop),
        .full    (full),
        .empty   (empty),
        .head    (head_job)
    );

    tcc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .empty         (empty),
        .head          (head_job),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_seq_out     (m_seq_out),
        .m_ack_out     (m_ack_out),
        .m_send_len    (m_send_len),
        .m_recv_len    (m_recv_len),
        .m_conn_state  (m_conn_state),
        .m_close_event (m_close_event),
        .m_last        (m_last)
    );

endmodule

[sv/tcc_checker.sv]
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks on the result channel of the connection state machine.
// ----------------------------------------------------------------------------
module tcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_action,
    input logic [31:0] m_seq_out,
    input logic [31:0] m_ack_out,
    input logic [15:0] m_send_len,
    input logic [15:0] m_recv_len
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action) && $stable(m_seq_out))
        else $error("result changed while stalled");

    // nothing offered right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // an event-only result carries no numbers
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == tcc_pkg::ACT_NONE |-> m_seq_out == 32'd0 && m_ack_out == 32'd0)
        else $error("numbers on a result without segment");

    // only data segments carry send length
    a_slen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_len != 16'd0 |-> m_action == tcc_pkg::ACT_DATA)
        else $error("send length on a non-data result");

    // delivered payload only comes with an acknowledgement
    a_rlen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_recv_len != 16'd0 |->
            m_action == tcc_pkg::ACT_ACK || m_action == tcc_pkg::ACT_FINACK)
        else $error("received length without acknowledgement");

endmodule

bind tcp_client_connection_fsm_top tcc_checker u_tcc_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_action   (m_action),
    .m_seq_out  (m_seq_out),
    .m_ack_out  (m_ack_out),
    .m_send_len (m_send_len),
    .m_recv_len (m_recv_len)
);

[bench/tcp_client_connection_fsm_top_tb.sv]
// ----------------------------------------------------------------------------
// tcp_client_connection_fsm_top_tb
// Self-checking bench for the client connection state machine. A scoreboard
// class tracks the connection on every accepted input and queues the segment
// actions it should produce. A monitor compares every result transfer with
// the oldest queued action. Stimulus is a short directed walk through the
// connection life cycle, then phases of random sessions with noise, each
// under its own initial sequence number and, in most phases, with random stalls on both ports.
// ----------------------------------------------------------------------------
module tcp_client_connection_fsm_top_tb;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 60;
    localparam int RANDOM_ITEMS  = 500;
    localparam int NUM_PHASES    = 8;

    // flag bits the classifier never tests alone, though they spoil exact flag matches
    localparam logic [8:0] F_PSH = 9'h008;
    localparam logic [8:0] F_ECE = 9'h040;

    typedef struct {
        tcc_pkg::mode_t mode;
        logic [8:0]     flags;
        logic [31:0]    seq;
        logic [3:0]     doff;
        logic [15:0]    seg_len;
        logic [15:0]    send_size;
    } conn_item_t;

    typedef struct {
        tcc_pkg::action_t      act;
        logic [31:0]           seq;
        logic [31:0]           ack;
        logic [15:0]           slen;
        logic [15:0]           rlen;
        tcc_pkg::link_state_t  state;
        tcc_pkg::close_event_t ev;
        logic                  last;
    } conn_action_t;

    class conn_scoreboard;
        tcc_pkg::link_state_t link;
        logic [31:0]          isn;
        logic [31:0]          own_seq;
        logic [31:0]          peer_ack;
        logic [15:0]          held_len;
        conn_action_t         staged[$];
        conn_action_t         due_actions[$];
        int                   errors;

        function new();
            link     = tcc_pkg::ST_CLOSED;
            isn      = 32'd0;
            own_seq  = 32'd0;
            peer_ack = 32'd0;
            held_len = 16'd0;
            errors   = 0;
        endfunction

        function void set_isn(logic [31:0] v);
            isn = v;
        endfunction

        function int pending();
            return due_actions.size();
        endfunction

        // numbers are taken as they stand when the segment is emitted
        function void stage(tcc_pkg::action_t act, logic [15:0] slen, logic [15:0] rlen,
                            tcc_pkg::close_event_t ev);
            conn_action_t r;
            r.act   = act;
            r.seq   = (act == tcc_pkg::ACT_NONE) ? 32'd0 : own_seq;
            r.ack   = (act == tcc_pkg::ACT_NONE) ? 32'd0 : peer_ack;
            r.slen  = slen;
            r.rlen  = rlen;
            r.state = tcc_pkg::ST_CLOSED;
            r.ev    = ev;
            r.last  = 1'b0;
            staged.push_back(r);
        endfunction

        function void take_ack(logic [8:0] flags, logic [31:0] seq, logic [15:0] payload);
            peer_ack = seq + 32'(payload) +
                       (((flags & (tcc_pkg::F_SYN | tcc_pkg::F_FIN)) != 0) ? 32'd1 : 32'd0);
        endfunction

        function void note_input(conn_item_t it);
            logic [15:0] hdr;
            logic [15:0] payload;
            logic        syn, ack, fin, rst;
            hdr     = {10'd0, it.doff, 2'b00};
            payload = (it.seg_len > hdr) ? it.seg_len - hdr : 16'd0;
            syn     = (it.flags & tcc_pkg::F_SYN) != 0;
            ack     = (it.flags & tcc_pkg::F_ACK) != 0;
            fin     = (it.flags & tcc_pkg::F_FIN) != 0;
            rst     = (it.flags & tcc_pkg::F_RST) != 0;
            staged.delete();
            case (it.mode)
                tcc_pkg::MODE_SEND: begin
                    if (link == tcc_pkg::ST_CLOSED) begin
                        held_len = it.send_size;
                        own_seq  = isn;
                        link     = tcc_pkg::ST_SYN_SENT;
                        stage(tcc_pkg::ACT_SYN, 16'd0, 16'd0, tcc_pkg::EV_NONE);
                    end else begin
                        stage(tcc_pkg::ACT_DATA, it.send_size, 16'd0, tcc_pkg::EV_NONE);
                        own_seq = own_seq + 32'(it.send_size);
                    end
                end
                tcc_pkg::MODE_CLOSE: begin
                    if (link == tcc_pkg::ST_ESTABLISHED) begin
                        stage(tcc_pkg::ACT_FINACK, 16'd0, 16'd0, tcc_pkg::EV_NONE);
                        link = tcc_pkg::ST_FIN_WAIT_1;
                    end
                end
                tcc_pkg::MODE_SEGMENT: begin
                    if ((it.flags & (tcc_pkg::F_NS | tcc_pkg::F_CWR | tcc_pkg::F_URG)) != 0)
                    begin
                        stage(tcc_pkg::ACT_RST, 16'd0, 16'd0, tcc_pkg::EV_NONE);
                    end else if (syn && ack && link == tcc_pkg::ST_SYN_SENT) begin
                        // handshake answer: ack, then the held-back first send
                        own_seq = own_seq + 32'd1;
                        take_ack(it.flags, it.seq, payload);
                        stage(tcc_pkg::ACT_ACK, 16'd0, 16'd0, tcc_pkg::EV_NONE);
                        link = tcc_pkg::ST_ESTABLISHED;
                        stage(tcc_pkg::ACT_DATA, held_len, 16'd0, tcc_pkg::EV_NONE);
                        own_seq  = own_seq + 32'(held_len);
                        held_len = 16'd0;
                    end else if (it.flags == tcc_pkg::F_ACK &&
                                 link == tcc_pkg::ST_CLOSE_WAIT) begin
                        link = tcc_pkg::ST_CLOSED;
                        stage(tcc_pkg::ACT_NONE, 16'd0, 16'd0, tcc_pkg::EV_NORMAL);
                    end else if (fin && ack && link == tcc_pkg::ST_FIN_WAIT_1) begin
                        take_ack(it.flags, it.seq, payload);
                        stage(tcc_pkg::ACT_ACK, 16'd0, 16'd0, tcc_pkg::EV_NORMAL);
                        link = tcc_pkg::ST_CLOSED;
                    end else if (it.flags == (tcc_pkg::F_RST | tcc_pkg::F_ACK) &&
                                 link == tcc_pkg::ST_SYN_SENT) begin
                        link = tcc_pkg::ST_CLOSED;
                        stage(tcc_pkg::ACT_NONE, 16'd0, 16'd0, tcc_pkg::EV_REFUSED);
                    end else if (ack && link == tcc_pkg::ST_ESTABLISHED) begin
                        // a bare ack with nothing to deliver stays silent
                        if (payload != 0 || fin) begin
                            take_ack(it.flags, it.seq, payload);
                            stage(fin ? tcc_pkg::ACT_FINACK : tcc_pkg::ACT_ACK,
                                  16'd0, payload, tcc_pkg::EV_NONE);
                            if (fin) link = tcc_pkg::ST_CLOSE_WAIT;
                        end
                    end else if (rst) begin
                        link = tcc_pkg::ST_CLOSED;
                        stage(tcc_pkg::ACT_NONE, 16'd0, 16'd0, tcc_pkg::EV_RESET);
                    end else begin
                        stage(tcc_pkg::ACT_RST, 16'd0, 16'd0, tcc_pkg::EV_UNKNOWN);
                        link = tcc_pkg::ST_CLOSED;
                    end
                end
                default: ;
            endcase
            foreach (staged[i]) begin
                staged[i].state = link;
                staged[i].last  = (i == staged.size() - 1);
                due_actions.push_back(staged[i]);
            end
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(conn_action_t got);
            conn_action_t want;
            if (due_actions.size() == 0) begin
                $error("result transfer with nothing expected: action %0d", got.act);
                errors++;
                return;
            end
            want = due_actions.pop_front();
            cmp("action", want.act, got.act);
            cmp("seq_out", want.seq, got.seq);
            cmp("ack_out", want.ack, got.ack);
            cmp("send_len", want.slen, got.slen);
            cmp("recv_len", want.rlen, got.rlen);
            cmp("conn_state", want.state, got.state);
            cmp("close_event", want.ev, got.ev);
            cmp("last", want.last, got.last);
        endfunction
    endclass

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        cfg_wr_en        = 1'b0;
    logic [31:0] cfg_wr_data      = 32'd0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode           = 2'd0;
    logic [8:0]  s_flags          = 9'd0;
    logic [31:0] s_seq_in         = 32'd0;
    logic [3:0]  s_data_offset    = 4'd0;
    logic [15:0] s_segment_length = 16'd0;
    logic [15:0] s_send_size      = 16'd0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [2:0]  m_action;
    logic [31:0] m_seq_out;
    logic [31:0] m_ack_out;
    logic [15:0] m_send_len;
    logic [15:0] m_recv_len;
    logic [2:0]  m_conn_state;
    logic [2:0]  m_close_event;
    logic        m_last;

    conn_scoreboard sb;
    bit src_gaps  = 1'b1;
    bit sink_gaps = 1'b1;
    bit sink_hold = 1'b0;
    int counted   = 0;
    int cycle_count = 0;

    tcp_client_connection_fsm_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_flags          (s_flags),
        .s_seq_in         (s_seq_in),
        .s_data_offset    (s_data_offset),
        .s_segment_length (s_segment_length),
        .s_send_size      (s_send_size),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_action         (m_action),
        .m_seq_out        (m_seq_out),
        .m_ack_out        (m_ack_out),
        .m_send_len       (m_send_len),
        .m_recv_len       (m_recv_len),
        .m_conn_state     (m_conn_state),
        .m_close_event    (m_close_event),
        .m_last           (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        conn_action_t got;
        if (aresetn && m_valid && m_ready) begin
            got.act   = tcc_pkg::action_t'(m_action);
            got.seq   = m_seq_out;
            got.ack   = m_ack_out;
            got.slen  = m_send_len;
            got.rlen  = m_recv_len;
            got.state = tcc_pkg::link_state_t'(m_conn_state);
            got.ev    = tcc_pkg::close_event_t'(m_close_event);
            got.last  = m_last;
            sb.check_result(got);
        end
    end

    // result side: random stall bursts, plus one long hold on request
    initial begin : sink
        int gap;
        @(posedge aclk);
        forever begin
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                sink_hold = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    function automatic conn_item_t noise_item();
        conn_item_t it;
        it.mode      = tcc_pkg::mode_t'($urandom_range(0, 3));
        it.flags     = 9'($urandom);
        it.seq       = $urandom;
        it.doff      = 4'($urandom);
        it.seg_len   = 16'($urandom);
        it.send_size = 16'($urandom);
        return it;
    endfunction

    function automatic conn_item_t seg_item(logic [8:0] flags, logic [31:0] seq,
                                            logic [3:0] doff, logic [15:0] len);
        conn_item_t it = noise_item();
        it.mode    = tcc_pkg::MODE_SEGMENT;
        it.flags   = flags;
        it.seq     = seq;
        it.doff    = doff;
        it.seg_len = len;
        return it;
    endfunction

    function automatic conn_item_t req_item(tcc_pkg::mode_t m, logic [15:0] size);
        conn_item_t it = noise_item();
        it.mode      = m;
        it.send_size = size;
        return it;
    endfunction

    // mostly short segments, now and then anything up to the field maximum
    function automatic logic [15:0] rand_len();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
    endfunction

    function automatic logic [8:0] harmless();
        return 9'($urandom) & (F_PSH | F_ECE);
    endfunction

    // valid stays high across back-to-back transfers, lowered only for a gap
    task automatic offer(conn_item_t it);
        int gap;
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_mode           <= it.mode;
        s_flags          <= it.flags;
        s_seq_in         <= it.seq;
        s_data_offset    <= it.doff;
        s_segment_length <= it.seg_len;
        s_send_size      <= it.send_size;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
        if (it.mode == tcc_pkg::MODE_SEGMENT || it.mode == tcc_pkg::MODE_SEND) counted++;
    endtask

    // hold the source until every queued action has come out
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_isn(logic [31:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_isn(v);
    endtask

    task automatic run_directed();
        offer(req_item(tcc_pkg::MODE_CLOSE, 16'd0));
        offer(req_item(tcc_pkg::MODE_UNUSED, 16'hFFFF));
        offer(seg_item(tcc_pkg::F_URG, $urandom, 4'd5, 16'd20));
        offer(seg_item(9'h000, 32'd0, 4'd0, 16'd0));
        offer(seg_item(tcc_pkg::F_RST, 32'hFFFF_FFFF, 4'd15, 16'hFFFF));
        offer(req_item(tcc_pkg::MODE_SEND, 16'hFFFF));
        offer(seg_item(tcc_pkg::F_RST | tcc_pkg::F_ACK, $urandom, 4'd5, 16'd20));
        offer(req_item(tcc_pkg::MODE_SEND, 16'd16));
        // acknowledgement number wraps to zero
        offer(seg_item(tcc_pkg::F_SYN | tcc_pkg::F_ACK, 32'hFFFF_FFFF, 4'd0, 16'd0));
        offer(seg_item(tcc_pkg::F_ACK | F_PSH, $urandom, 4'd5, 16'hFFFF));
        // header longer than the segment: payload saturates, nothing to say
        offer(seg_item(tcc_pkg::F_ACK, $urandom, 4'd15, 16'd10));
        offer(req_item(tcc_pkg::MODE_SEND, 16'hFFFF));
        offer(seg_item(tcc_pkg::F_CWR | tcc_pkg::F_ACK, $urandom, 4'd5, 16'd40));
        offer(seg_item(tcc_pkg::F_NS, $urandom, 4'd5, 16'd40));
        offer(req_item(tcc_pkg::MODE_CLOSE, 16'd0));
        offer(req_item(tcc_pkg::MODE_SEND, 16'd0));
        offer(seg_item(tcc_pkg::F_FIN | tcc_pkg::F_SYN | tcc_pkg::F_ACK, 32'hFFFF_FFFE,
                       4'd5, 16'd21));
        write_isn(32'hFFFF_FFFF);
        offer(req_item(tcc_pkg::MODE_SEND, 16'd5));
        offer(seg_item(tcc_pkg::F_SYN | tcc_pkg::F_ACK | F_PSH, 32'd100, 4'd5, 16'd40));
        offer(seg_item(tcc_pkg::F_FIN | tcc_pkg::F_ACK, $urandom, 4'd5, 16'd20));
        offer(seg_item(tcc_pkg::F_ACK, $urandom, 4'd5, 16'd20));
        offer(req_item(tcc_pkg::MODE_SEND, 16'd1));
        offer(seg_item(tcc_pkg::F_ACK, $urandom, 4'd5, 16'd20));
        offer(req_item(tcc_pkg::MODE_SEND, 16'd2));
        offer(seg_item(tcc_pkg::F_RST, $urandom, 4'd5, 16'd20));
    endtask

    // open, exchange, close; noise mixed in breaks some sessions on purpose
    task automatic run_session();
        int steps;
        steps = $urandom_range(1, 6);
        offer(req_item(tcc_pkg::MODE_SEND, rand_len()));
        if ($urandom_range(0, 7) == 0) begin
            offer(seg_item(tcc_pkg::F_RST | tcc_pkg::F_ACK, $urandom, 4'($urandom),
                           rand_len()));
            return;
        end
        offer(seg_item(tcc_pkg::F_SYN | tcc_pkg::F_ACK | harmless(), $urandom,
                       4'($urandom), rand_len()));
        repeat (steps) begin
            case ($urandom_range(0, 6))
                0:       offer(req_item(tcc_pkg::MODE_SEND, rand_len()));
                1, 2:    offer(seg_item(tcc_pkg::F_ACK | harmless(), $urandom,
                                        4'($urandom), rand_len()));
                3:       offer(seg_item(tcc_pkg::F_ACK | harmless(), $urandom, 4'd5,
                                        16'($urandom_range(0, 20))));
                4:       offer(noise_item());
                5:       offer(seg_item(9'($urandom), $urandom, 4'($urandom), rand_len()));
                default: offer(seg_item(tcc_pkg::F_ACK, $urandom, 4'd5, rand_len()));
            endcase
        end
        case ($urandom_range(0, 4))
            0, 1: begin
                offer(req_item(tcc_pkg::MODE_CLOSE, 16'($urandom)));
                offer(seg_item(tcc_pkg::F_FIN | tcc_pkg::F_ACK | harmless(), $urandom,
                               4'($urandom), rand_len()));
            end
            2: begin
                offer(seg_item(tcc_pkg::F_FIN | tcc_pkg::F_ACK | harmless(), $urandom,
                               4'($urandom), rand_len()));
                offer(seg_item(tcc_pkg::F_ACK, $urandom, 4'($urandom), rand_len()));
            end
            3:       offer(seg_item(tcc_pkg::F_RST | harmless(), $urandom, 4'($urandom),
                                    rand_len()));
            default: offer(noise_item());
        endcase
    endtask

    initial begin : stimulus
        int          start;
        logic [31:0] isn;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       isn = 32'd0;
                1:       isn = 32'hFFFF_FFFF;
                default: isn = $urandom;
            endcase
            write_isn(isn);
            // phase 2 streams without gaps into a long receiver hold
            src_gaps  = (phase != 2) && (phase != NUM_PHASES - 1);
            sink_gaps = (phase != NUM_PHASES - 1);
            if (phase == 2) sink_hold = 1'b1;
            start = counted;
            while (counted - start < RANDOM_ITEMS / NUM_PHASES) run_session();
        end
        settle();
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
